// ===== rtl/randomized_leaky_relu_top_assert.svh =====
// Assertion macros for the randomized leaky ReLU block.
// Used by the port checker; needs clock and reset in scope.
`ifndef RANDOMIZED_LEAKY_RELU_TOP_ASSERT_SVH
`define RANDOMIZED_LEAKY_RELU_TOP_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define RRELU_ASSERT_NOW(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("rrelu check failed");

// Condition holds in the cycle after the trigger.
`define RRELU_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("rrelu check failed");

`endif

// ===== rtl/rrelu_pkg.sv =====
// Shared types and constants for the randomized leaky ReLU block.
// No dependencies.
package rrelu_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int MT_N       = 624;
   localparam int MT_M       = 397;
   localparam int POS_W      = 10;
   localparam int SLOPE_W    = 25;
   localparam int MUL_W      = 33;

   localparam logic [31:0] MT_MATRIX  = 32'h9908_B0DF;
   localparam logic [31:0] MT_SEED_K  = 32'd1812433253;
   localparam logic [31:0] TEMPER_B   = 32'h9D2C_5680;
   localparam logic [31:0] TEMPER_C   = 32'hEFC6_0000;
   localparam logic [31:0] SEED_RESET = 32'd5489;
   localparam logic [SLOPE_W-1:0] LOW_RESET  = 25'd2097152;
   localparam logic [SLOPE_W-1:0] HIGH_RESET = 25'd5592405;
   localparam logic [SLOPE_W-1:0] SLOPE_ONE  = 25'd16777216;

   localparam logic [1:0] CSR_SLOPE_LOW  = 2'd0;
   localparam logic [1:0] CSR_SLOPE_HIGH = 2'd1;
   localparam logic [1:0] CSR_RNG_SEED   = 2'd2;

   typedef enum logic [3:0] {
      ST_SEED0,
      ST_SMUL,
      ST_SWR,
      ST_IDLE,
      ST_GA,
      ST_GB,
      ST_GC,
      ST_GD,
      ST_SLMUL,
      ST_SLADD,
      ST_RESMUL,
      ST_RESOUT
   } state_type;

   function automatic logic [31:0] temper(input logic [31:0] v);
      logic [31:0] t;
      t = v ^ (v >> 11);
      t = t ^ ((t << 7) & TEMPER_B);
      t = t ^ ((t << 15) & TEMPER_C);
      t = t ^ (t >> 18);
      return t;
   endfunction

endpackage

// ===== rtl/rrelu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrelu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rrelu_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on rrelu_pkg.
module rrelu_mul (
   input  logic                                clock,
   input  logic signed [rrelu_pkg::MUL_W-1:0]  mul_a,
   input  logic signed [rrelu_pkg::MUL_W-1:0]  mul_b,
   output logic signed [2*rrelu_pkg::MUL_W-1:0] mul_p
);

   logic signed [2*rrelu_pkg::MUL_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign mul_p = prod_ff;

endmodule

// ===== rtl/randomized_leaky_relu_top.sv =====
// Randomized leaky ReLU top level: sequencer, MT19937 word store, shared multiplier.
// Depends on rrelu_pkg, rrelu_ram and rrelu_mul.
//
// A non-negative activation returns itself with slope one in the cycle after it is
// accepted. A negative activation draws two MT19937 words, each generated in place
// from three reads of the single-read-port word RAM plus one write, then computes
// slope and product in the one shared multiplier. After reset and after every seed
// write the generator is seeded one word at a time (multiply, then add and write),
// during which req_ready stays low. The block holds one transaction at a time.
module randomized_leaky_relu_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [31:0] req_activation,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_result_value,
   output logic [24:0] rsp_applied_slope,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int PW = rrelu_pkg::POS_W;
   localparam int MW = rrelu_pkg::MUL_W;
   localparam int SW = rrelu_pkg::SLOPE_W;
   localparam int FB = rrelu_pkg::FRAC_BITS;

   rrelu_pkg::state_type state_ff, state_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [31:0]   prev_ff, prev_in;
   logic [31:0]   w0_ff, w0_in;
   logic [31:0]   y_ff, y_in;
   logic [31:0]   draw_ff, draw_in;
   logic          second_ff, second_in;
   logic signed [31:0] act_ff, act_in;
   logic [SW-1:0] slope_ff, slope_in;
   logic [SW-1:0] low_ff, low_in;
   logic [SW-1:0] high_ff, high_in;
   logic [31:0]   seed_ff, seed_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] res_ff, res_in;
   logic [SW-1:0] rslope_ff, rslope_in;

   logic          ram_we;
   logic [PW-1:0] ram_waddr, ram_raddr;
   logic [31:0]   ram_wdata, ram_rdata;
   logic signed [MW-1:0]   mul_a, mul_b;
   logic signed [2*MW-1:0] mul_p;

   logic [PW-1:0] pos_next, pos_far;
   logic [31:0]   gen_word, seed_word;
   logic signed [SW:0] diff;
   logic signed [SW+1:0] slope_sum;
   logic          accept;

   rrelu_ram #(.WIDTH(32), .DEPTH(rrelu_pkg::MT_N)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   rrelu_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == rrelu_pkg::ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_value  = res_ff;
   assign rsp_applied_slope = rslope_ff;

   always_comb begin
      pos_next = (pos_ff == PW'(rrelu_pkg::MT_N - 1)) ? '0 : pos_ff + PW'(1);
      pos_far  = (pos_ff >= PW'(rrelu_pkg::MT_N - rrelu_pkg::MT_M))
               ? pos_ff - PW'(rrelu_pkg::MT_N - rrelu_pkg::MT_M)
               : pos_ff + PW'(rrelu_pkg::MT_M);
      gen_word = ram_rdata ^ (y_ff >> 1) ^ (y_ff[0] ? rrelu_pkg::MT_MATRIX : 32'd0);
      seed_word = mul_p[31:0] + {{(32-PW){1'b0}}, pos_ff};
      diff = $signed({1'b0, high_ff}) - $signed({1'b0, low_ff});
      slope_sum = $signed({2'b00, low_ff}) + mul_p[FB+SW+1:FB];
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      prev_in      = prev_ff;
      w0_in        = w0_ff;
      y_in         = y_ff;
      draw_in      = draw_ff;
      second_in    = second_ff;
      act_in       = act_ff;
      slope_in     = slope_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      seed_in      = seed_ff;
      rsp_valid_in = rsp_valid_ff;
      res_in       = res_ff;
      rslope_in    = rslope_ff;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff;
      ram_wdata    = gen_word;
      ram_raddr    = pos_ff;
      mul_a        = $signed({1'b0, prev_ff ^ (prev_ff >> 30)});
      mul_b        = $signed({1'b0, rrelu_pkg::MT_SEED_K});

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         rrelu_pkg::ST_SEED0: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = seed_ff;
            prev_in   = seed_ff;
            pos_in    = PW'(1);
            state_in  = rrelu_pkg::ST_SMUL;
         end
         rrelu_pkg::ST_SMUL: begin
            state_in = rrelu_pkg::ST_SWR;
         end
         rrelu_pkg::ST_SWR: begin
            ram_we    = 1'b1;
            ram_wdata = seed_word;
            prev_in   = seed_word;
            if (pos_ff == PW'(rrelu_pkg::MT_N - 1)) begin
               pos_in   = '0;
               state_in = rrelu_pkg::ST_IDLE;
            end else begin
               pos_in   = pos_ff + PW'(1);
               state_in = rrelu_pkg::ST_SMUL;
            end
         end
         rrelu_pkg::ST_IDLE: begin
            if (accept) begin
               act_in = req_activation;
               if (req_activation[31]) begin
                  second_in = 1'b0;
                  state_in  = rrelu_pkg::ST_GA;
               end else begin
                  rsp_valid_in = 1'b1;
                  res_in       = req_activation;
                  rslope_in    = rrelu_pkg::SLOPE_ONE;
               end
            end
         end
         rrelu_pkg::ST_GA: begin
            state_in = rrelu_pkg::ST_GB;
         end
         rrelu_pkg::ST_GB: begin
            ram_raddr = pos_next;
            w0_in     = ram_rdata;
            state_in  = rrelu_pkg::ST_GC;
         end
         rrelu_pkg::ST_GC: begin
            ram_raddr = pos_far;
            y_in      = {w0_ff[31], ram_rdata[30:0]};
            state_in  = rrelu_pkg::ST_GD;
         end
         rrelu_pkg::ST_GD: begin
            ram_we  = 1'b1;
            draw_in = rrelu_pkg::temper(gen_word);
            pos_in  = pos_next;
            if (second_ff) begin
               state_in = rrelu_pkg::ST_SLMUL;
            end else begin
               second_in = 1'b1;
               state_in  = rrelu_pkg::ST_GA;
            end
         end
         rrelu_pkg::ST_SLMUL: begin
            mul_a    = $signed({{(MW-FB){1'b0}}, draw_ff[FB-1:0]});
            mul_b    = MW'(diff);
            state_in = rrelu_pkg::ST_SLADD;
         end
         rrelu_pkg::ST_SLADD: begin
            slope_in = slope_sum[SW-1:0];
            state_in = rrelu_pkg::ST_RESMUL;
         end
         rrelu_pkg::ST_RESMUL: begin
            mul_a    = MW'(act_ff);
            mul_b    = $signed({{(MW-SW){1'b0}}, slope_ff});
            state_in = rrelu_pkg::ST_RESOUT;
         end
         rrelu_pkg::ST_RESOUT: begin
            // saturate when the floored product leaves 32 bits
            if (mul_p[2*MW-1:FB+31] == '0 || mul_p[2*MW-1:FB+31] == '1) begin
               res_in = mul_p[FB+31:FB];
            end else if (mul_p[2*MW-1]) begin
               res_in = 32'sh8000_0000;
            end else begin
               res_in = 32'sh7FFF_FFFF;
            end
            rslope_in    = slope_ff;
            rsp_valid_in = 1'b1;
            state_in     = rrelu_pkg::ST_IDLE;
         end
         default: begin
            state_in = rrelu_pkg::ST_IDLE;
         end
      endcase

      if (csr_write) begin
         case (csr_index)
            rrelu_pkg::CSR_SLOPE_LOW:  low_in  = csr_data[SW-1:0];
            rrelu_pkg::CSR_SLOPE_HIGH: high_in = csr_data[SW-1:0];
            rrelu_pkg::CSR_RNG_SEED: begin
               seed_in  = csr_data;
               state_in = rrelu_pkg::ST_SEED0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrelu_pkg::ST_SEED0;
         rsp_valid_ff <= 1'b0;
         low_ff       <= rrelu_pkg::LOW_RESET;
         high_ff      <= rrelu_pkg::HIGH_RESET;
         seed_ff      <= rrelu_pkg::SEED_RESET;
         pos_ff       <= '0;
         second_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         seed_ff      <= seed_in;
         pos_ff       <= pos_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff   <= prev_in;
      w0_ff     <= w0_in;
      y_ff      <= y_in;
      draw_ff   <= draw_in;
      act_ff    <= act_in;
      slope_ff  <= slope_in;
      res_ff    <= res_in;
      rslope_ff <= rslope_in;
   end

endmodule

// ===== rtl/rrelu_checker.sv =====
// Port-level checker for the randomized leaky ReLU block, bound to the top level.
// Depends on randomized_leaky_relu_top_assert.svh.
`include "randomized_leaky_relu_top_assert.svh"

module rrelu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic signed [31:0] req_activation,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic signed [31:0] rsp_result_value,
   input logic [24:0] rsp_applied_slope
);

   `RRELU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value) && $stable(rsp_applied_slope))
   `RRELU_ASSERT_NEXT(a_pass, req_valid && req_ready && !req_activation[31], rsp_valid && rsp_result_value == $past(req_activation) && rsp_applied_slope == 25'd16777216)
   `RRELU_ASSERT_NOW(a_one_open, rsp_valid, !req_ready)

endmodule

bind randomized_leaky_relu_top rrelu_checker u_rrelu_checker (.*);

// ===== tb/randomized_leaky_relu_top_tb.sv =====
// Self-checking testbench for the randomized leaky ReLU block: directed and random activations
// through valid/ready channels, checked against an in-bench MT19937 slope predictor.
// Depends on rrelu_pkg and randomized_leaky_relu_top.
module randomized_leaky_relu_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic signed [31:0] value;
      logic [24:0]        slope;
   } relu_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_activation = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_result_value;
   logic [24:0]        rsp_applied_slope;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;

   // predictor state
   logic [24:0] pred_low;
   logic [24:0] pred_high;
   logic [31:0] mt_words [rrelu_pkg::MT_N];
   int          mt_pos;

   relu_result_type pending_results [$];
   int              mismatches = 0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;

   randomized_leaky_relu_top dut (.*);

   always #6 clock = ~clock;

   function automatic void mt_seed(logic [31:0] s);
      mt_words[0] = s;
      for (int i = 1; i < rrelu_pkg::MT_N; i++)
         mt_words[i] = 32'd1812433253 * (mt_words[i-1] ^ (mt_words[i-1] >> 30)) + i;
      mt_pos = rrelu_pkg::MT_N;
   endfunction

   function automatic logic [31:0] mt_next();
      logic [31:0] y;
      logic [31:0] v;
      if (mt_pos >= rrelu_pkg::MT_N) begin
         for (int i = 0; i < rrelu_pkg::MT_N; i++) begin
            y = (mt_words[i] & 32'h8000_0000) |
                (mt_words[(i + 1) % rrelu_pkg::MT_N] & 32'h7FFF_FFFF);
            v = mt_words[(i + rrelu_pkg::MT_M) % rrelu_pkg::MT_N] ^ (y >> 1);
            if (y[0]) v = v ^ rrelu_pkg::MT_MATRIX;
            mt_words[i] = v;
         end
         mt_pos = 0;
      end
      y = mt_words[mt_pos];
      mt_pos++;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & 32'h9D2C_5680);
      y = y ^ ((y << 15) & 32'hEFC6_0000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   function automatic relu_result_type predict_relu(logic signed [31:0] act);
      relu_result_type r;
      longint frac;
      longint span;
      longint sl;
      longint prod;
      if (act >= 0) begin
         r.value = act;
         r.slope = rrelu_pkg::SLOPE_ONE;
         return r;
      end
      void'(mt_next());
      frac = longint'(mt_next() & 32'h00FF_FFFF);
      span = longint'(pred_high) - longint'(pred_low);
      sl = longint'(pred_low) + ((frac * span) >>> rrelu_pkg::FRAC_BITS);
      prod = (longint'(act) * sl) >>> rrelu_pkg::FRAC_BITS;
      if (prod < -64'sd2147483648) prod = -64'sd2147483648;
      if (prod > 64'sd2147483647) prod = 64'sd2147483647;
      r.value = prod[31:0];
      r.slope = sl[24:0];
      return r;
   endfunction

   // receiver stall pattern
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      relu_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result value=%0d slope=%0d",
                        rsp_result_value, rsp_applied_slope);
         end else begin
            e = pending_results.pop_front();
            if (e.value !== rsp_result_value || e.slope !== rsp_applied_slope) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch: expected value=%0d slope=%0d,",
                            " got value=%0d slope=%0d"},
                           e.value, e.slope, rsp_result_value, rsp_applied_slope);
            end
         end
      end
   end

   task automatic send_activation(logic signed [31:0] act);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_activation <= act;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(predict_relu(act));
   endtask

   // drop valid, then let the block drain before touching registers
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         rrelu_pkg::CSR_SLOPE_LOW:  pred_low = data[24:0];
         rrelu_pkg::CSR_SLOPE_HIGH: pred_high = data[24:0];
         rrelu_pkg::CSR_RNG_SEED:   mt_seed(data);
         default: ;
      endcase
   endtask

   function automatic logic signed [31:0] random_activation();
      case ($urandom_range(3))
         0: return $urandom;
         1: return -$signed({16'd0, 16'($urandom)}) - 1;
         2: return $signed(32'($urandom_range(65535)));
         default: return -$signed(32'($urandom_range(1 << 24)));
      endcase
   endfunction

   task automatic test_activation_extremes();
      logic signed [31:0] acts [10] = '{0, 1, 32'h7FFF_FFFF, 32'h8000_0000, -1, -65536,
                                         65536, -2, 32'h8000_0001, -32'sd12345};
      foreach (acts[i]) send_activation(acts[i]);
      drain();
   endtask

   task automatic test_bound_cases();
      // reversed bounds
      write_csr(rrelu_pkg::CSR_SLOPE_LOW, rrelu_pkg::SLOPE_ONE);
      write_csr(rrelu_pkg::CSR_SLOPE_HIGH, 32'd0);
      repeat (3) send_activation(-32'sd65536);
      send_activation(32'h8000_0000);
      drain();
      // both bounds at the 25-bit maximum: saturate on the most negative input
      write_csr(rrelu_pkg::CSR_SLOPE_LOW, 32'hFFFF_FFFF);
      write_csr(rrelu_pkg::CSR_SLOPE_HIGH, 32'h01FF_FFFF);
      send_activation(32'h8000_0000);
      send_activation(-32'sd7);
      drain();
      write_csr(rrelu_pkg::CSR_SLOPE_LOW, 32'd0);
      write_csr(rrelu_pkg::CSR_SLOPE_HIGH, 32'd0);
      write_csr(CSR_UNUSED, 32'hFFFF_FFFF);
      send_activation(-32'sd100000);
      send_activation(-32'sd1);
      drain();
   endtask

   task automatic test_seed_reload();
      write_csr(rrelu_pkg::CSR_RNG_SEED, 32'd0);
      write_csr(rrelu_pkg::CSR_SLOPE_LOW, 32'd0);
      write_csr(rrelu_pkg::CSR_SLOPE_HIGH, rrelu_pkg::SLOPE_ONE);
      repeat (3) send_activation(-32'sd65536);
      drain();
      write_csr(rrelu_pkg::CSR_RNG_SEED, 32'hFFFF_FFFF);
      repeat (2) send_activation(-32'sd65536);
      drain();
   endtask

   task automatic test_random_traffic(int send_pct, int recv_pct, int count);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      write_csr(rrelu_pkg::CSR_SLOPE_LOW, $urandom_range(rrelu_pkg::SLOPE_ONE));
      write_csr(rrelu_pkg::CSR_SLOPE_HIGH, $urandom_range(1 << 25) - 1);
      if ($urandom_range(1)) write_csr(rrelu_pkg::CSR_RNG_SEED, $urandom);
      // send count random activations of mixed sign, each negative one drawing two words
      repeat (count) send_activation(random_activation());
      drain();
   endtask

   initial begin
      pred_low = rrelu_pkg::LOW_RESET;
      pred_high = rrelu_pkg::HIGH_RESET;
      mt_seed(rrelu_pkg::SEED_RESET);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_activation_extremes();
      test_bound_cases();
      test_seed_reload();
      test_random_traffic(0, 0, 240);
      test_random_traffic(68, 0, 235);
      test_random_traffic(0, 68, 235);
      test_random_traffic(18, 18, 240);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
